### rtl/csc_tmv_pkg.sv
// shared types and constants for the transposed csc sparse matrix-vector block
`timescale 1ns / 1ps

package csc_tmv_pkg;

  // fixed field widths
  localparam int unsigned ROW_BITS = 12;
  localparam int unsigned COL_BITS = 16;
  localparam int unsigned OP_BITS  = 2;

  // item kind carried on the input tuser
  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } op_e;

endpackage

### rtl/sparse_csc_transpose_matvec_top.sv
// top level of the transposed csc sparse matrix times dense vector block
`timescale 1ns / 1ps

// usage
//   input stream (s_axis): tuser carries the item kind (load vector element, nonzero
//   matrix entry, empty column), tdata the row index and the q1.15 value, tlast marks
//   the nonzero entry that closes its column. load items fill the vector ram first;
//   nonzero entries then stream column by column and are multiply-accumulated.
//   output stream (m_axis): one transaction per closed or empty column with the column
//   index and the rounded, saturated sum in tdata, the clip flag in tuser and tlast on
//   the final column of the matrix.
//   config channel: one register, the column count, written while the block is idle.
// timing
//   one input transaction per cycle while the output is not stalled; a result passes
//   the ram read, product register and sum register before the output register.
//   the vector ram's registered read port sets the first stage.
// reset
//   accumulator and column counter clear, column count returns to one, all stages
//   empty; the vector ram is not cleared and must be loaded before use.
// stalls
//   when the receiver holds tready low with a result waiting, the whole pipeline
//   freezes and s_axis_tready drops until the output register is taken.

module sparse_csc_transpose_matvec_top #(
  parameter int unsigned VECTOR_DEPTH = 4096,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: row_index, value (lowest bit first), zero padded to bytes
  input  logic [((csc_tmv_pkg::ROW_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: operation
  input  logic [csc_tmv_pkg::OP_BITS-1:0] s_axis_tuser,
  input  logic s_axis_tlast,

  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: column_index, column_sum (lowest bit first), zero padded to bytes
  output logic [((csc_tmv_pkg::COL_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: saturated
  output logic [0:0] m_axis_tuser,
  output logic m_axis_tlast,

  // configuration write channel: column count
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [csc_tmv_pkg::COL_BITS-1:0] cfg_data_i
);

  import csc_tmv_pkg::*;

  localparam int unsigned ADDR_BITS = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int unsigned REXT_BITS = (ADDR_BITS > ROW_BITS) ? ADDR_BITS : ROW_BITS;
  localparam int unsigned PROD_BITS = 2 * VALUE_BITS;
  localparam int unsigned ACC_RAW   = 2 * VALUE_BITS + 12;
  localparam int unsigned ACC_BITS  = (ACC_RAW > 62) ? 62 : ACC_RAW;
  localparam int unsigned SUM_BITS  = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
  localparam int unsigned FRAC_BITS = VALUE_BITS - 1;
  localparam int unsigned OUT_W     = ((COL_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam logic [ACC_BITS:0] HALF_LSB = (ACC_BITS + 1)'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------- handshakes
  logic adv;        // whole pipeline moves
  logic in_fire;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- input unpack
  op_e                    in_op;
  logic [ROW_BITS-1:0]    in_row;
  logic [VALUE_BITS-1:0]  in_value;
  logic [REXT_BITS-1:0]   in_row_ext;
  logic                   in_row_ok;

  assign in_op      = op_e'(s_axis_tuser);
  assign in_row     = s_axis_tdata[ROW_BITS-1:0];
  assign in_value   = s_axis_tdata[ROW_BITS +: VALUE_BITS];
  assign in_row_ext = REXT_BITS'(in_row);
  // rows past the ram depth are dropped on load and read as zero
  assign in_row_ok  = 32'(in_row) < 32'(VECTOR_DEPTH);

  // ---------------------------------------------------------------- column count register
  logic [COL_BITS-1:0] col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= COL_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      col_count_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- vector ram
  logic                  ram_we;
  logic                  ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;

  assign ram_we = in_fire && (in_op == OP_LOAD) && in_row_ok;
  assign ram_re = in_fire && (in_op == OP_NONZERO);

  csc_tmv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_row_ext[ADDR_BITS-1:0]),
    .wdata_i (in_value),
    .re_i    (ram_re),
    .raddr_i (in_row_ext[ADDR_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1: item + ram read
  logic                  s1_valid_q;
  logic                  s1_empty_q;
  logic                  s1_last_q;
  logic                  s1_row_ok_q;
  logic [VALUE_BITS-1:0] s1_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      // loads and unused codes end here
      s1_valid_q <= in_fire && ((in_op == OP_NONZERO) || (in_op == OP_EMPTY));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_empty_q  <= (in_op == OP_EMPTY);
      s1_last_q   <= s_axis_tlast;
      s1_row_ok_q <= in_row_ok;
      s1_value_q  <= in_value;
    end
  end

  // ---------------------------------------------------------------- stage 2: product
  logic signed [VALUE_BITS-1:0] mul_a;
  logic signed [VALUE_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  mul_p;

  assign mul_a = signed'(s1_value_q);
  assign mul_b = s1_row_ok_q ? signed'(ram_rdata) : '0;
  assign mul_p = mul_a * mul_b;

  logic                        s2_valid_q;
  logic                        s2_empty_q;
  logic                        s2_last_q;
  logic signed [PROD_BITS-1:0] s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_empty_q <= s1_empty_q;
      s2_last_q  <= s1_last_q;
      s2_prod_q  <= mul_p;
    end
  end

  // ---------------------------------------------------------------- stage 3: accumulate
  logic signed [ACC_BITS-1:0] acc_q;
  logic signed [ACC_BITS-1:0] acc_d;
  logic signed [SUM_BITS-1:0] sum_w;
  logic                       sum_fits;
  logic                       s2_close;

  assign sum_w    = SUM_BITS'(acc_q) + SUM_BITS'(s2_prod_q);
  assign sum_fits = (&sum_w[SUM_BITS-1:ACC_BITS-1]) || !(|sum_w[SUM_BITS-1:ACC_BITS-1]);
  assign s2_close = s2_empty_q || s2_last_q;

  // accumulator clips at its own bounds rather than wrapping
  always_comb begin
    if (sum_fits) begin
      acc_d = sum_w[ACC_BITS-1:0];
    end else if (sum_w[SUM_BITS-1]) begin
      acc_d = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      acc_d = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  logic                       s3_valid_q;
  logic signed [ACC_BITS-1:0] s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q && s2_close;
      if (s2_valid_q) begin
        acc_q <= s2_close ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      // an empty column drops any partial sum and reports zero
      s3_sum_q <= s2_empty_q ? '0 : acc_d;
    end
  end

  // ---------------------------------------------------------------- stage 4: round, column count
  logic signed [ACC_BITS:0]     rnd_w;
  logic signed [ACC_BITS:0]     q_w;
  logic                         q_fits;
  logic signed [VALUE_BITS-1:0] q_sat;
  logic [COL_BITS:0]            col_next;
  logic [COL_BITS:0]            col_limit;
  logic                         col_last;
  logic [COL_BITS-1:0]          col_q;

  // round half up, then arithmetic shift gives the floor for both signs
  assign rnd_w  = (ACC_BITS + 1)'(s3_sum_q) + signed'(HALF_LSB);
  assign q_w    = rnd_w >>> FRAC_BITS;
  assign q_fits = (&q_w[ACC_BITS:VALUE_BITS-1]) || !(|q_w[ACC_BITS:VALUE_BITS-1]);

  always_comb begin
    if (q_fits) begin
      q_sat = q_w[VALUE_BITS-1:0];
    end else if (q_w[ACC_BITS]) begin
      q_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  // a zero column count stands for the full 16-bit range
  assign col_next  = {1'b0, col_q} + (COL_BITS + 1)'(1);
  assign col_limit = (col_count_q == '0) ? {1'b1, {COL_BITS{1'b0}}} : {1'b0, col_count_q};
  assign col_last  = col_next >= col_limit;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic                  out_sat_q;
  logic                  out_last_q;
  logic [OUT_W-1:0]      out_data_d;

  always_comb begin
    out_data_d                          = '0;
    out_data_d[COL_BITS-1:0]            = col_q;
    out_data_d[COL_BITS +: VALUE_BITS]  = q_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      col_q       <= '0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        col_q <= col_last ? '0 : col_next[COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      out_data_q <= out_data_d;
      out_sat_q  <= !q_fits;
      out_last_q <= col_last;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;
  assign m_axis_tlast    = out_last_q;

  // ---------------------------------------------------------------- assertions
  // a closing column always leaves the accumulator cleared
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q && s2_close) |=> (acc_q == '0))
    else $error("accumulator not cleared after column close");

  // the final column wraps the column counter back to zero
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_valid_q && col_last) |=> (col_q == '0))
    else $error("column counter did not wrap");

  // a clipped result carries one of the two range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |->
      ((out_data_q[COL_BITS +: VALUE_BITS] == {1'b1, {(VALUE_BITS-1){1'b0}}}) ||
       (out_data_q[COL_BITS +: VALUE_BITS] == {1'b0, {(VALUE_BITS-1){1'b1}}})))
    else $error("saturation flag without a range limit");

  // pipeline holds every stage while the output is blocked
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv) |=> $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s3_valid_q))
    else $error("pipeline moved during output stall");

endmodule

### rtl/csc_tmv_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module csc_tmv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
